### hw/rtl/imsu_pkg.sv
// Shared constants and codes for the Ising Metropolis spin update block.
package imsu_pkg;

    localparam int DEF_ROWS = 32;
    localparam int DEF_COLS = 32;

    // Field widths fixed by the item formats.
    localparam int ROW_W    = 5;
    localparam int COL_W    = 5;
    localparam int RND_W    = 16;
    localparam int DE_W     = 5;
    localparam int ENERGY_W = 13;
    localparam int MAG_W    = 12;
    localparam int THR_W    = 16;

    localparam int CFG_IDX_W = 8;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_DE4 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THR_DE8 = CFG_IDX_W'(1);

    localparam logic KIND_TRIAL = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

endpackage

### hw/rtl/ising_metropolis_spin_update.sv
// Metropolis spin update engine for a periodic 2D Ising lattice.
//
// One item is accepted every cycle unless the result beat ahead of it is stalled; the item
// passes through the registered read of the row memories taken at acceptance and then the
// result register. The lattice is held as three copies of a
// row-wide memory (rows above, at and below the site), each read once per item;
// the flip of the item one beat ahead is forwarded past the memories. Rows carry
// valid bits that reset clears, so an unwritten row reads as all spins down and
// no clearing pass is needed after reset. A trial flips when dE <= 0 or when the
// random value is below the threshold for dE of 4 or 8; a write forces the spin.
module ising_metropolis_spin_update
    import imsu_pkg::*;
#(
    parameter int LATTICE_ROWS = DEF_ROWS,
    parameter int LATTICE_COLS = DEF_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input beats.
    input  logic                  i_in_tvalid,
    output logic                  o_in_tready,
    // tdata from bit 0: row[4:0], col[9:5], random_value[25:10], spin_value[26], zeros
    input  logic [IN_DATA_W-1:0]  i_in_tdata,
    // tuser: kind[0]
    input  logic                  i_in_tuser,
    // Result beats.
    output logic                  o_out_tvalid,
    input  logic                  i_out_tready,
    // tdata from bit 0: flipped[0], spin_after[1], energy_change[6:2],
    // total_energy[19:7], total_magnetization[31:20]
    output logic [OUT_DATA_W-1:0] o_out_tdata,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [THR_W-1:0]      i_cfg_data
);

    localparam int RW = $clog2(LATTICE_ROWS);
    localparam int CW = $clog2(LATTICE_COLS);
    localparam int SITES = LATTICE_ROWS * LATTICE_COLS;
    localparam logic [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(-2 * SITES);
    localparam logic [MAG_W-1:0]    MAG_RST    = MAG_W'(-SITES);
    localparam logic [RW-1:0] ROW_LAST = RW'(LATTICE_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(LATTICE_COLS - 1);

    // Reduce a narrow coordinate modulo n by repeated subtraction; n >= 4 and
    // the value is below 32, so eight steps always suffice.
    function automatic logic [8:0] wrap_coord(input logic [4:0] v, input int n);
        logic [8:0] t;
        logic [8:0] lim;
        t   = {4'd0, v};
        lim = 9'(n);
        for (int k = 0; k < 8; k++) begin
            if (t >= lim) begin
                t = t - lim;
            end
        end
        return t;
    endfunction

    logic [THR_W-1:0] r_thr_de4;
    logic [THR_W-1:0] r_thr_de8;

    // Row memories and per-row valid bits.
    logic [LATTICE_COLS-1:0] r_mem_up  [LATTICE_ROWS];
    logic [LATTICE_COLS-1:0] r_mem_ctr [LATTICE_ROWS];
    logic [LATTICE_COLS-1:0] r_mem_dn  [LATTICE_ROWS];
    logic [LATTICE_ROWS-1:0] r_row_ok;

    // Stage 1: item register and row read data.
    logic                    r_s1_v;
    logic                    r_s1_kind;
    logic [RW-1:0]           r_s1_row;
    logic [RW-1:0]           r_s1_rup;
    logic [RW-1:0]           r_s1_rdn;
    logic [CW-1:0]           r_s1_col;
    logic [RND_W-1:0]        r_s1_rnd;
    logic                    r_s1_wval;
    logic [LATTICE_COLS-1:0] r_rd_up;
    logic [LATTICE_COLS-1:0] r_rd_ctr;
    logic [LATTICE_COLS-1:0] r_rd_dn;
    logic                    r_ok_up;
    logic                    r_ok_ctr;
    logic                    r_ok_dn;

    // Row written on the same edge as the stage 1 read.
    logic                    r_fwd_v;
    logic [RW-1:0]           r_fwd_row;
    logic [LATTICE_COLS-1:0] r_fwd_data;

    logic [ENERGY_W-1:0]     r_energy;
    logic [MAG_W-1:0]        r_mag;

    logic                    r_out_v;
    logic [OUT_DATA_W-1:0]   r_out_data;

    logic                    load;
    logic                    s1_adv;
    logic [RW-1:0]           in_row;
    logic [RW-1:0]           in_rup;
    logic [RW-1:0]           in_rdn;
    logic [CW-1:0]           in_col;
    logic [LATTICE_COLS-1:0] row_up;
    logic [LATTICE_COLS-1:0] row_ctr;
    logic [LATTICE_COLS-1:0] row_dn;
    logic [CW-1:0]           col_lf;
    logic [CW-1:0]           col_rt;
    logic                    spin;
    logic [2:0]              up_count;
    logic signed [5:0]       de_up;
    logic signed [5:0]       de_wide;
    logic [DE_W-1:0]         de;
    logic                    flip;
    logic                    w_en;
    logic [LATTICE_COLS-1:0] n_row_data;
    logic [ENERGY_W-1:0]     n_energy;
    logic [MAG_W-1:0]        n_mag;
    logic                    spin_after;

    assign s1_adv      = r_s1_v && (!r_out_v || i_out_tready);
    assign o_in_tready = !r_s1_v || s1_adv;
    assign load        = i_in_tvalid && o_in_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        logic [8:0] wr;
        logic [8:0] wc;
        wr     = wrap_coord(i_in_tdata[4:0], LATTICE_ROWS);
        wc     = wrap_coord(i_in_tdata[9:5], LATTICE_COLS);
        in_row = wr[RW-1:0];
        in_col = wc[CW-1:0];
        in_rup = (in_row == '0) ? ROW_LAST : in_row - RW'(1);
        in_rdn = (in_row == ROW_LAST) ? '0 : in_row + RW'(1);
    end

    // Stage 2: rows with valid masking and forwarding, then the decision.
    always_comb begin
        row_up  = r_ok_up  ? r_rd_up  : '0;
        row_ctr = r_ok_ctr ? r_rd_ctr : '0;
        row_dn  = r_ok_dn  ? r_rd_dn  : '0;
        if (r_fwd_v && r_fwd_row == r_s1_rup) begin
            row_up = r_fwd_data;
        end
        if (r_fwd_v && r_fwd_row == r_s1_row) begin
            row_ctr = r_fwd_data;
        end
        if (r_fwd_v && r_fwd_row == r_s1_rdn) begin
            row_dn = r_fwd_data;
        end

        col_lf = (r_s1_col == '0) ? COL_LAST : r_s1_col - CW'(1);
        col_rt = (r_s1_col == COL_LAST) ? '0 : r_s1_col + CW'(1);

        spin     = row_ctr[r_s1_col];
        up_count = 3'(row_up[r_s1_col]) + 3'(row_dn[r_s1_col])
                 + 3'(row_ctr[col_lf]) + 3'(row_ctr[col_rt]);
        // With k neighbours up the sum is 2k-4, so dE is 4k-8 for an up spin.
        de_up   = $signed({1'b0, up_count, 2'b00}) - 6'sd8;
        de_wide = spin ? de_up : -de_up;
        de      = de_wide[DE_W-1:0];

        if (r_s1_kind == KIND_WRITE) begin
            flip = (r_s1_wval != spin);
        end else if (de[DE_W-1] || de == '0) begin
            flip = 1'b1;
        end else if (de == DE_W'(4)) begin
            flip = r_s1_rnd < r_thr_de4;
        end else if (de == DE_W'(8)) begin
            flip = r_s1_rnd < r_thr_de8;
        end else begin
            flip = 1'b0;
        end

        n_row_data           = row_ctr;
        n_row_data[r_s1_col] = ~spin;
        spin_after           = spin ^ flip;
        n_energy = flip ? r_energy + {{(ENERGY_W-DE_W){de[DE_W-1]}}, de} : r_energy;
        n_mag    = flip ? (spin ? r_mag - MAG_W'(2) : r_mag + MAG_W'(2)) : r_mag;
    end

    assign w_en = s1_adv && flip;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem_up[r_s1_row]  <= n_row_data;
            r_mem_ctr[r_s1_row] <= n_row_data;
            r_mem_dn[r_s1_row]  <= n_row_data;
        end
        if (load) begin
            r_rd_up  <= r_mem_up[in_rup];
            r_rd_ctr <= r_mem_ctr[in_row];
            r_rd_dn  <= r_mem_dn[in_rdn];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok  <= '0;
            r_s1_v    <= 1'b0;
            r_fwd_v   <= 1'b0;
            r_out_v   <= 1'b0;
            r_energy  <= ENERGY_RST;
            r_mag     <= MAG_RST;
            r_thr_de4 <= '0;
            r_thr_de8 <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_THR_DE4: r_thr_de4 <= i_cfg_data;
                    CFG_THR_DE8: r_thr_de8 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load) begin
                r_ok_up  <= r_row_ok[in_rup];
                r_ok_ctr <= r_row_ok[in_row];
                r_ok_dn  <= r_row_ok[in_rdn];
                r_fwd_v  <= w_en;
            end
            if (w_en) begin
                r_row_ok[r_s1_row] <= 1'b1;
                r_energy           <= n_energy;
                r_mag              <= n_mag;
            end
            if (load) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
            end else if (i_out_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_kind  <= i_in_tuser;
            r_s1_row   <= in_row;
            r_s1_rup   <= in_rup;
            r_s1_rdn   <= in_rdn;
            r_s1_col   <= in_col;
            r_s1_rnd   <= i_in_tdata[25:10];
            r_s1_wval  <= i_in_tdata[26];
            r_fwd_row  <= r_s1_row;
            r_fwd_data <= n_row_data;
        end
        if (s1_adv) begin
            r_out_data <= {n_mag, n_energy, de, spin_after, flip};
        end
    end

    assign o_out_tvalid = r_out_v;
    assign o_out_tdata  = r_out_data;

endmodule

### hw/rtl/imsu_checker.sv
// Port-level checks for the Ising Metropolis spin update block, bound to the top level.
module imsu_checker
    import imsu_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_tvalid,
    input logic                  i_out_tready,
    input logic [OUT_DATA_W-1:0] o_out_tdata
);

    // A stalled result beat must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_tvalid && !i_out_tready |=> o_out_tvalid && $stable(o_out_tdata))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_tvalid)
        else $error("result valid right after reset");

    // The energy change is always a multiple of four.
    a_de_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_tvalid |-> o_out_tdata[3:2] == 2'b00)
        else $error("energy change not a multiple of four");

    // Total energy starts even and moves in steps of four, so it stays even.
    a_energy_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_tvalid |-> !o_out_tdata[7])
        else $error("total energy is odd");

endmodule

bind ising_metropolis_spin_update imsu_checker u_imsu_checker (.*);

### bench/ising_metropolis_spin_update_tb.sv
// Self-checking testbench for the Ising Metropolis spin update block.
module ising_metropolis_spin_update_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import imsu_pkg::*;

    localparam int ROWS       = DEF_ROWS;
    localparam int COLS       = DEF_COLS;
    localparam int QUIET_MAX  = 2000;
    localparam int SHOW_MAX   = 10;

    typedef struct packed {
        logic             kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [RND_W-1:0] rnd;
        logic             spin;
    } t_site_item;

    typedef struct packed {
        logic                       flipped;
        logic                       spin_after;
        logic signed [DE_W-1:0]     de;
        logic signed [ENERGY_W-1:0] energy;
        logic signed [MAG_W-1:0]    mag;
    } t_spin_result;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_tvalid = 1'b0;
    logic                  in_tready;
    logic [IN_DATA_W-1:0]  in_tdata  = '0;
    logic                  in_tuser  = KIND_TRIAL;
    logic                  out_tvalid;
    logic                  out_tready = 1'b0;
    logic [OUT_DATA_W-1:0] out_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [THR_W-1:0]      cfg_data  = '0;

    // Mirror of the block's lattice, running totals and thresholds.
    bit                         spins [ROWS][COLS];
    logic signed [ENERGY_W-1:0] energy_sum = ENERGY_W'(-2 * ROWS * COLS);
    logic signed [MAG_W-1:0]    mag_sum    = MAG_W'(-ROWS * COLS);
    logic [THR_W-1:0]           thr_de4    = '0;
    logic [THR_W-1:0]           thr_de8    = '0;

    t_site_item   pending_sites[$];
    t_spin_result expected_updates[$];
    t_site_item   cur_site;

    int gap_pct = 0;
    int stall_pct = 0;
    int gap_left = 0;
    int stall_left = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int trial_count = 0;
    int write_count = 0;
    int flip_count = 0;
    int de4_accepts = 0;
    int de8_accepts = 0;
    int reg_writes = 0;

    ising_metropolis_spin_update #(
        .LATTICE_ROWS(ROWS),
        .LATTICE_COLS(COLS)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tvalid  (in_tvalid),
        .o_in_tready  (in_tready),
        .i_in_tdata   (in_tdata),
        .i_in_tuser   (in_tuser),
        .o_out_tvalid (out_tvalid),
        .i_out_tready (out_tready),
        .o_out_tdata  (out_tdata),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int spin_sign(int r, int c);
        return spins[r][c] ? 1 : -1;
    endfunction

    // Applies one beat to the mirror lattice and returns the result it must produce.
    function automatic t_spin_result update_site(t_site_item it);
        int r, c, up, dn, lf, rt, s, nsum, de;
        logic flip;
        t_spin_result res;
        r = it.row % ROWS;
        c = it.col % COLS;
        up = (r == 0) ? ROWS - 1 : r - 1;
        dn = (r == ROWS - 1) ? 0 : r + 1;
        lf = (c == 0) ? COLS - 1 : c - 1;
        rt = (c == COLS - 1) ? 0 : c + 1;
        s = spin_sign(r, c);
        nsum = spin_sign(up, c) + spin_sign(dn, c) + spin_sign(r, lf) + spin_sign(r, rt);
        de = 2 * s * nsum;
        if (it.kind == KIND_TRIAL) begin
            trial_count++;
            if (de <= 0) begin
                flip = 1'b1;
            end else if (de == 4) begin
                flip = it.rnd < thr_de4;
                if (flip) de4_accepts++;
            end else if (de == 8) begin
                flip = it.rnd < thr_de8;
                if (flip) de8_accepts++;
            end else begin
                flip = 1'b0;
            end
        end else begin
            write_count++;
            flip = (it.spin != spins[r][c]);
        end
        if (flip) begin
            flip_count++;
            spins[r][c] = ~spins[r][c];
            energy_sum += ENERGY_W'(de);
            mag_sum -= MAG_W'(2 * s);
        end
        res.flipped    = flip;
        res.spin_after = spins[r][c];
        res.de         = DE_W'(de);
        res.energy     = energy_sum;
        res.mag        = mag_sum;
        return res;
    endfunction

    // Input driver: holds each beat until it is taken, then may idle for a short burst.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_tvalid <= 1'b0;
        end else begin
            if (in_tvalid && in_tready) begin
                expected_updates.push_back(update_site(cur_site));
            end
            if (!in_tvalid || in_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_tvalid <= 1'b0;
                end else if (pending_sites.size() == 0) begin
                    in_tvalid <= 1'b0;
                end else begin
                    cur_site = pending_sites.pop_front();
                    in_tdata <= {5'b0, cur_site.spin, cur_site.rnd, cur_site.col, cur_site.row};
                    in_tuser <= cur_site.kind;
                    in_tvalid <= 1'b1;
                    if ($urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 5);
                end
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge clk) begin
        t_spin_result want, got;
        if (!rst_n) begin
            out_tready <= 1'b0;
        end else begin
            if (out_tvalid && out_tready) begin
                got.flipped    = out_tdata[0];
                got.spin_after = out_tdata[1];
                got.de         = out_tdata[6:2];
                got.energy     = out_tdata[19:7];
                got.mag        = out_tdata[31:20];
                if (expected_updates.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display("Unexpected result beat at %0t: tdata %h", $realtime, out_tdata);
                end else begin
                    want = expected_updates.pop_front();
                    if (got.flipped !== want.flipped || got.spin_after !== want.spin_after ||
                        got.de !== want.de || got.energy !== want.energy ||
                        got.mag !== want.mag) begin
                        fail_count++;
                        if (fail_count <= SHOW_MAX)
                            $display({"Mismatch at %0t (expected/actual): flipped %0d/%0d ",
                                      "spin %0d/%0d dE %0d/%0d energy %0d/%0d mag %0d/%0d"},
                                     $realtime, want.flipped, got.flipped, want.spin_after,
                                     got.spin_after, want.de, got.de, want.energy, got.energy,
                                     want.mag, got.mag);
                    end
                end
            end
            if (stall_left > 1) begin
                stall_left--;
                out_tready <= 1'b0;
            end else if (stall_left == 1) begin
                stall_left = 0;
                out_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 5);
                out_tready <= 1'b0;
            end else begin
                out_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk) begin
        if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_MAX) begin
                $display("Timeout: no beat accepted for %0d cycles", QUIET_MAX);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic void push_site(logic kind, int row, int col, int rnd, logic spin);
        t_site_item it;
        it.kind = kind;
        it.row  = ROW_W'(row);
        it.col  = COL_W'(col);
        it.rnd  = RND_W'(rnd);
        it.spin = spin;
        pending_sites.push_back(it);
    endfunction

    task automatic wait_drained();
        @(posedge clk);
        while (pending_sites.size() != 0 || in_tvalid || expected_updates.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_THR_DE4) thr_de4 = val;
        else if (idx == CFG_THR_DE8) thr_de8 = val;
    endtask

    // One random phase: new thresholds, then two halves with a full drain between them.
    task automatic run_phase(input logic [THR_W-1:0] t4, input logic [THR_W-1:0] t8,
                             input int count, input int gp, input int sp);
        int pick, rnd, row, col;
        wait_drained();
        write_reg(CFG_THR_DE4, t4);
        write_reg(CFG_THR_DE8, t8);
        gap_pct = gp;
        stall_pct = sp;
        for (int h = 0; h < 2; h++) begin
            for (int i = 0; i < count / 2; i++) begin
                // Half the sites fall in a small window around the corner so that
                // neighbors interact and the wrap-around is exercised often.
                if ($urandom_range(0, 1)) begin
                    row = 30 + $urandom_range(0, 3);
                    col = 30 + $urandom_range(0, 3);
                end else begin
                    row = $urandom_range(0, 31);
                    col = $urandom_range(0, 31);
                end
                pick = $urandom_range(0, 99);
                if (pick < 8)       rnd = int'(thr_de4);
                else if (pick < 16) rnd = int'(thr_de4) - 1;
                else if (pick < 24) rnd = int'(thr_de8);
                else if (pick < 32) rnd = int'(thr_de8) - 1;
                else if (pick < 36) rnd = 0;
                else if (pick < 40) rnd = 16'hFFFF;
                else                rnd = $urandom_range(0, 16'hFFFF);
                push_site(($urandom_range(0, 99) < 20) ? KIND_WRITE : KIND_TRIAL,
                          row, col, rnd, 1'($urandom_range(0, 1)));
            end
            wait_drained();
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct = 25;
        stall_pct = 25;

        // All spins down and both thresholds zero: positive dE never flips.
        push_site(KIND_TRIAL, 0, 0, 0, 0);
        push_site(KIND_TRIAL, 31, 31, 16'hFFFF, 1);
        push_site(KIND_WRITE, 0, 0, 16'hFFFF, 1);
        push_site(KIND_WRITE, 0, 0, 0, 1);              // same value again, no change
        push_site(KIND_TRIAL, 0, 1, 0, 0);
        push_site(KIND_TRIAL, 0, 31, 0, 0);             // column wraps onto the corner
        push_site(KIND_TRIAL, 31, 0, 0, 0);             // row wraps onto the corner
        push_site(KIND_WRITE, 0, 1, 0, 1);
        push_site(KIND_WRITE, 1, 0, 16'h5A5A, 1);
        push_site(KIND_TRIAL, 0, 0, 16'hFFFF, 0);       // zero dE flips
        push_site(KIND_WRITE, 0, 31, 16'hA5A5, 1);
        push_site(KIND_WRITE, 31, 0, 0, 1);
        push_site(KIND_TRIAL, 0, 0, 16'hFFFF, 0);       // dE of -8 flips
        push_site(KIND_TRIAL, 0, 1, 16'hFFFF, 0);       // dE of -4 flips
        push_site(KIND_WRITE, 0, 31, 0, 0);
        wait_drained();

        // Highest thresholds; writes to unused register indexes must do nothing.
        write_reg(CFG_THR_DE4, '1);
        write_reg(CFG_THR_DE8, '1);
        write_reg(CFG_IDX_W'(2), 16'h1234);
        write_reg('1, '0);
        push_site(KIND_TRIAL, 16, 16, 16'hFFFE, 0);
        push_site(KIND_TRIAL, 16, 17, 16'hFFFF, 0);
        push_site(KIND_TRIAL, 16, 17, 16'hFFFE, 0);
        push_site(KIND_TRIAL, 20, 20, 16'hFFFF, 0);
        wait_drained();

        // Lowest nonzero thresholds: only a zero random value passes.
        write_reg(CFG_THR_DE4, 16'd1);
        write_reg(CFG_THR_DE8, 16'd1);
        push_site(KIND_TRIAL, 20, 20, 1, 0);
        push_site(KIND_TRIAL, 20, 20, 0, 0);
        push_site(KIND_TRIAL, 20, 21, 1, 0);
        push_site(KIND_TRIAL, 20, 21, 0, 0);

        run_phase(THR_W'($urandom), THR_W'($urandom), 320, 20, 20);
        run_phase('0, '0, 260, 30, 10);
        run_phase('1, '1, 260, 40, 40);
        run_phase(THR_W'($urandom_range(0, 4095)), THR_W'($urandom_range(0, 255)), 300, 0, 0);
        run_phase(THR_W'($urandom), THR_W'($urandom), 300, 0, 0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_updates.size() != 0) begin
            fail_count += expected_updates.size();
            $display("%0d expected results never arrived", expected_updates.size());
        end
        $display("Covered %0d Metropolis trials and %0d spin writes, %0d of which changed a spin.",
                 trial_count, write_count, flip_count);
        $display("Threshold acceptances: %0d at dE 4 and %0d at dE 8, over %0d register writes.",
                 de4_accepts, de8_accepts, reg_writes);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
